@@ rtl/dsw_pkg.sv @@
// Package for the search-window table: widths, table entry type, sequencer states,
// command codes and move encodings. No dependencies.
`default_nettype none
package dsw_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 10;
    localparam int CFG_W    = 11;
    localparam int CNT_W    = 21;
    localparam int CADDR_W  = $clog2(MAX_COLS);
    // signed width wide enough for a coordinate plus or minus a radius and a pullback
    localparam int SW       = ROW_W + 3;

    localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);
    localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_EXPAND = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_NUM_COLS = 1'b0,
        REG_NUM_ROWS = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_QUERY,
        S_RMW,
        S_COPY,
        S_CDRAIN,
        S_SRD,
        S_SCAP,
        S_MOVE
    } state_t;

    typedef struct packed {
        logic             used;
        logic [ROW_W-1:0] lo;
        logic [ROW_W-1:0] hi;
    } entry_t;

    // one neighbor target produced by the move unit
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } move_t;

    // direction of a move: bit 1 = negative, bit 0 = positive, both low = stay
    typedef logic [1:0] dir_t;
    localparam dir_t DIR_NEG  = 2'b10;
    localparam dir_t DIR_POS  = 2'b01;
    localparam dir_t DIR_ZERO = 2'b00;

    function automatic dir_t move_dc(input logic [2:0] m);
        dir_t d;
        case (m)
            3'd0, 3'd3, 3'd5: d = DIR_NEG;
            3'd2, 3'd4, 3'd7: d = DIR_POS;
            default:          d = DIR_ZERO;
        endcase
        return d;
    endfunction

    function automatic dir_t move_dr(input logic [2:0] m);
        dir_t d;
        case (m)
            3'd0, 3'd1, 3'd2: d = DIR_POS;
            3'd5, 3'd6, 3'd7: d = DIR_NEG;
            default:          d = DIR_ZERO;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

@@ rtl/dsw_ram.sv @@
// Simple dual-port synchronous RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module dsw_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 21
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/dsw_move.sv @@
// Neighbor target for one cell and one of the eight moves, pulled back onto the
// matrix edge along the move direction. Depends on dsw_pkg.
`default_nettype none
module dsw_move (
    input  wire logic [dsw_pkg::COL_W-1:0] col,
    input  wire logic [dsw_pkg::ROW_W-1:0] row,
    input  wire logic [2:0]                move,
    input  wire logic [dsw_pkg::ROW_W-1:0] radius,
    input  wire logic [dsw_pkg::COL_W-1:0] max_col,
    input  wire logic [dsw_pkg::ROW_W-1:0] max_row,
    output dsw_pkg::move_t                 target
);

    localparam int SW = dsw_pkg::SW;

    dsw_pkg::dir_t dc, dr;
    logic signed [SW-1:0] c_s, r_s, rad_s, mi_s, mj_s;
    logic signed [SW-1:0] tc, tr, pc, pr, past, fc, fr;
    logic allowed;

    always_comb
    begin
        dc    = dsw_pkg::move_dc(move);
        dr    = dsw_pkg::move_dr(move);
        c_s   = $signed(SW'(col));
        r_s   = $signed(SW'(row));
        rad_s = $signed(SW'(radius));
        mi_s  = $signed(SW'(max_col));
        mj_s  = $signed(SW'(max_row));

        tc = (dc == dsw_pkg::DIR_NEG) ? c_s - rad_s :
             (dc == dsw_pkg::DIR_POS) ? c_s + rad_s : c_s;
        tr = (dr == dsw_pkg::DIR_NEG) ? r_s - rad_s :
             (dr == dsw_pkg::DIR_POS) ? r_s + rad_s : r_s;

        // overshoot past the edge in each dimension
        pc = (dc == dsw_pkg::DIR_NEG) ? -tc :
             (dc == dsw_pkg::DIR_POS) ? tc - mi_s : '0;
        pr = (dr == dsw_pkg::DIR_NEG) ? -tr :
             (dr == dsw_pkg::DIR_POS) ? tr - mj_s : '0;
        past = '0;
        if (pc > past)
        begin
            past = pc;
        end
        if (pr > past)
        begin
            past = pr;
        end

        fc = (dc == dsw_pkg::DIR_NEG) ? tc + past :
             (dc == dsw_pkg::DIR_POS) ? tc - past : tc;
        fr = (dr == dsw_pkg::DIR_NEG) ? tr + past :
             (dr == dsw_pkg::DIR_POS) ? tr - past : tr;

        // skip a move across an edge the cell already sits on
        allowed = 1'b1;
        if (dc == dsw_pkg::DIR_NEG && col == '0)
        begin
            allowed = 1'b0;
        end
        if (dc == dsw_pkg::DIR_POS && col == max_col)
        begin
            allowed = 1'b0;
        end
        if (dr == dsw_pkg::DIR_NEG && row == '0)
        begin
            allowed = 1'b0;
        end
        if (dr == dsw_pkg::DIR_POS && row == max_row)
        begin
            allowed = 1'b0;
        end

        target.en  = allowed && (fc >= 0) && (fc <= mi_s) && (fr >= 0) && (fr <= mj_s);
        target.col = fc[dsw_pkg::COL_W-1:0];
        target.row = fr[dsw_pkg::ROW_W-1:0];
    end

endmodule
`default_nettype wire

@@ rtl/dtw_search_window_table_top.sv @@
// Top level of the search-window table: sequencer around the window and snapshot RAMs.
// Depends on dsw_pkg, dsw_ram and dsw_move.
//
// Each request returns one result strobe (done) that the receiver must take in
// that cycle. A mark is one read-modify-write of the window RAM, a query one read
// of it; a mark outside the matrix writes nothing. Clear, a configuration write and
// reset run a clearing pass over all MAX_COLS (1024) entries of the window RAM; the
// block is busy meanwhile. Expand runs one or two passes; each pass copies the
// window to the snapshot RAM, then reads the snapshot column by column and, for
// each snapshot cell, tests its eight neighbors; each neighbor that lands inside
// the matrix is marked by a read-modify-write through the single read port of the
// window RAM.
`default_nettype none
module dtw_search_window_table_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  cmd,
    input  wire logic [dsw_pkg::COL_W-1:0]   col,
    input  wire logic [dsw_pkg::ROW_W-1:0]   row,
    input  wire logic [dsw_pkg::ROW_W-1:0]   radius,
    output logic                             done,
    output logic                             in_window,
    output logic                             column_empty,
    output logic [dsw_pkg::ROW_W-1:0]        col_min,
    output logic [dsw_pkg::ROW_W-1:0]        col_max,
    output logic [dsw_pkg::CNT_W-1:0]        cell_count,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [dsw_pkg::CFG_W-1:0]   cfg_data
);

    localparam int COL_W = dsw_pkg::COL_W;
    localparam int ROW_W = dsw_pkg::ROW_W;
    localparam int CNT_W = dsw_pkg::CNT_W;
    localparam int AW    = dsw_pkg::CADDR_W;
    localparam int EW    = $bits(dsw_pkg::entry_t);
    localparam logic [AW-1:0] LAST_ADDR = AW'(dsw_pkg::MAX_COLS - 1);

    dsw_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [2:0]       move_reg, move_next;
    logic             pass_reg, pass_next;
    logic [ROW_W-1:0] rad_reg, rad_next;
    logic [ROW_W-1:0] rad2_reg, rad2_next;
    logic [ROW_W-1:0] s_hi_reg, s_hi_next;
    logic [COL_W-1:0] tcol_reg, tcol_next;
    logic [ROW_W-1:0] trow_reg, trow_next;
    logic             walk_reg, walk_next;
    logic             respond_reg, respond_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [COL_W-1:0] mi_reg;
    logic [ROW_W-1:0] mj_reg;
    logic [ROW_W-1:0] q_row_reg;
    logic [COL_W-1:0] q_col_reg;
    logic             cpy_vld_reg;
    logic [AW-1:0]    cpy_addr_reg;

    logic             done_reg, in_window_reg, column_empty_reg;
    logic [ROW_W-1:0] col_min_reg, col_max_reg;
    logic [CNT_W-1:0] cell_count_reg;

    logic             finish;
    logic             res_in, res_empty;
    logic [ROW_W-1:0] res_min, res_max;

    logic             main_we;
    logic [AW-1:0]    main_waddr, main_raddr;
    dsw_pkg::entry_t  main_wdata, main_rdata;
    logic [AW-1:0]    snap_raddr;
    dsw_pkg::entry_t  snap_rdata;

    dsw_pkg::move_t   target;
    dsw_pkg::entry_t  upd;
    logic [CNT_W-1:0] upd_add;

    logic [COL_W-1:0] cfg_max;

    dsw_ram #(.DEPTH(dsw_pkg::MAX_COLS), .WIDTH(EW)) u_window (
        .clk   (clk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    dsw_ram #(.DEPTH(dsw_pkg::MAX_COLS), .WIDTH(EW)) u_snap (
        .clk   (clk),
        .we    (cpy_vld_reg),
        .waddr (cpy_addr_reg),
        .wdata (main_rdata),
        .raddr (snap_raddr),
        .rdata (snap_rdata)
    );

    dsw_move u_move (
        .col     (cnt_reg[COL_W-1:0]),
        .row     (cur_row_reg),
        .move    (move_reg),
        .radius  (rad_reg),
        .max_col (mi_reg),
        .max_row (mj_reg),
        .target  (target)
    );

    // clamp a register value to 1..MAX and keep it as the last index
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_max = '0;
        end
        else if (cfg_data > ((cfg_index == dsw_pkg::REG_NUM_COLS) ?
                             dsw_pkg::MAX_COLS_C : dsw_pkg::MAX_ROWS_C))
        begin
            cfg_max = (cfg_index == dsw_pkg::REG_NUM_COLS) ?
                      COL_W'(dsw_pkg::MAX_COLS - 1) : COL_W'(dsw_pkg::MAX_ROWS - 1);
        end
        else
        begin
            cfg_max = COL_W'(cfg_data - 1'b1);
        end
    end

    // widen the target column's range to include the target row
    always_comb
    begin
        upd     = main_rdata;
        upd_add = '0;
        if (!main_rdata.used)
        begin
            upd.used = 1'b1;
            upd.lo   = trow_reg;
            upd.hi   = trow_reg;
            upd_add  = CNT_W'(1);
        end
        else if (trow_reg < main_rdata.lo)
        begin
            upd.lo  = trow_reg;
            upd_add = CNT_W'(main_rdata.lo - trow_reg);
        end
        else if (trow_reg > main_rdata.hi)
        begin
            upd.hi  = trow_reg;
            upd_add = CNT_W'(trow_reg - main_rdata.hi);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cur_row_next = cur_row_reg;
        move_next    = move_reg;
        pass_next    = pass_reg;
        rad_next     = rad_reg;
        rad2_next    = rad2_reg;
        s_hi_next    = s_hi_reg;
        tcol_next    = tcol_reg;
        trow_next    = trow_reg;
        walk_next    = walk_reg;
        respond_next = respond_reg;
        total_next   = total_reg;
        finish       = 1'b0;
        res_in       = 1'b0;
        res_empty    = 1'b0;
        res_min      = '0;
        res_max      = '0;
        main_we      = 1'b0;
        main_waddr   = cnt_reg;
        main_wdata   = '0;
        main_raddr   = AW'(col);
        snap_raddr   = cnt_reg;

        unique case (state_reg)
            dsw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (dsw_pkg::cmd_t'(cmd))
                        dsw_pkg::CMD_CLEAR:
                        begin
                            total_next   = '0;
                            cnt_next     = '0;
                            respond_next = 1'b1;
                            state_next   = dsw_pkg::S_CLEAR;
                        end
                        dsw_pkg::CMD_MARK:
                        begin
                            if (col <= mi_reg && row <= mj_reg)
                            begin
                                tcol_next  = col;
                                trow_next  = row;
                                walk_next  = 1'b0;
                                state_next = dsw_pkg::S_RMW;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        dsw_pkg::CMD_QUERY:
                        begin
                            state_next = dsw_pkg::S_QUERY;
                        end
                        dsw_pkg::CMD_EXPAND:
                        begin
                            if (radius == '0)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                rad_next   = ROW_W'(1);
                                rad2_next  = radius - 1'b1;
                                pass_next  = 1'b0;
                                cnt_next   = '0;
                                state_next = dsw_pkg::S_COPY;
                            end
                        end
                        default:
                        begin
                            state_next = dsw_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            dsw_pkg::S_CLEAR:
            begin
                main_we    = 1'b1;
                main_waddr = cnt_reg;
                main_wdata = '0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = dsw_pkg::S_IDLE;
                    finish     = respond_reg;
                end
            end

            dsw_pkg::S_QUERY:
            begin
                finish = 1'b1;
                if (q_col_reg <= mi_reg && main_rdata.used)
                begin
                    res_in  = (q_row_reg >= main_rdata.lo) && (q_row_reg <= main_rdata.hi);
                    res_min = main_rdata.lo;
                    res_max = main_rdata.hi;
                end
                else
                begin
                    res_empty = 1'b1;
                end
                state_next = dsw_pkg::S_IDLE;
            end

            dsw_pkg::S_RMW:
            begin
                main_we    = 1'b1;
                main_waddr = AW'(tcol_reg);
                main_wdata = upd;
                total_next = total_reg + upd_add;
                if (walk_reg)
                begin
                    state_next = dsw_pkg::S_MOVE;
                    if (move_reg == 3'd7)
                    begin
                        move_next = '0;
                        if (cur_row_reg == s_hi_reg)
                        begin
                            state_next = dsw_pkg::S_SRD;
                            if (cnt_reg == AW'(mi_reg))
                            begin
                                cnt_next = '0;
                                if (!pass_reg && rad2_reg != '0)
                                begin
                                    pass_next  = 1'b1;
                                    rad_next   = rad2_reg;
                                    state_next = dsw_pkg::S_COPY;
                                end
                                else
                                begin
                                    finish     = 1'b1;
                                    state_next = dsw_pkg::S_IDLE;
                                end
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        move_next = move_reg + 1'b1;
                    end
                end
                else
                begin
                    finish     = 1'b1;
                    state_next = dsw_pkg::S_IDLE;
                end
            end

            dsw_pkg::S_COPY:
            begin
                main_raddr = cnt_reg;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == AW'(mi_reg))
                begin
                    cnt_next   = '0;
                    state_next = dsw_pkg::S_CDRAIN;
                end
            end

            dsw_pkg::S_CDRAIN:
            begin
                state_next = dsw_pkg::S_SRD;
            end

            dsw_pkg::S_SRD:
            begin
                snap_raddr = cnt_reg;
                state_next = dsw_pkg::S_SCAP;
            end

            dsw_pkg::S_SCAP:
            begin
                if (snap_rdata.used)
                begin
                    cur_row_next = snap_rdata.lo;
                    s_hi_next    = snap_rdata.hi;
                    move_next    = '0;
                    state_next   = dsw_pkg::S_MOVE;
                end
                else if (cnt_reg == AW'(mi_reg))
                begin
                    cnt_next = '0;
                    if (!pass_reg && rad2_reg != '0)
                    begin
                        pass_next  = 1'b1;
                        rad_next   = rad2_reg;
                        state_next = dsw_pkg::S_COPY;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        state_next = dsw_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = dsw_pkg::S_SRD;
                end
            end

            dsw_pkg::S_MOVE:
            begin
                main_raddr = AW'(target.col);
                if (target.en)
                begin
                    tcol_next  = target.col;
                    trow_next  = target.row;
                    walk_next  = 1'b1;
                    state_next = dsw_pkg::S_RMW;
                end
                else if (move_reg == 3'd7)
                begin
                    move_next = '0;
                    if (cur_row_reg == s_hi_reg)
                    begin
                        state_next = dsw_pkg::S_SRD;
                        if (cnt_reg == AW'(mi_reg))
                        begin
                            cnt_next = '0;
                            if (!pass_reg && rad2_reg != '0)
                            begin
                                pass_next  = 1'b1;
                                rad_next   = rad2_reg;
                                state_next = dsw_pkg::S_COPY;
                            end
                            else
                            begin
                                finish     = 1'b1;
                                state_next = dsw_pkg::S_IDLE;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                else
                begin
                    move_next = move_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = dsw_pkg::S_IDLE;
            end
        endcase

        // a register write empties the window with no result
        if (cfg_we)
        begin
            total_next   = '0;
            cnt_next     = '0;
            respond_next = 1'b0;
            state_next   = dsw_pkg::S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dsw_pkg::S_CLEAR;
            cnt_reg     <= '0;
            respond_reg <= 1'b0;
            total_reg   <= '0;
            mi_reg      <= COL_W'(dsw_pkg::MAX_COLS - 1);
            mj_reg      <= ROW_W'(dsw_pkg::MAX_ROWS - 1);
            cpy_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            respond_reg <= respond_next;
            total_reg   <= total_next;
            cpy_vld_reg <= (state_reg == dsw_pkg::S_COPY);
            done_reg    <= finish;
            if (cfg_we)
            begin
                if (cfg_index == dsw_pkg::REG_NUM_COLS)
                begin
                    mi_reg <= cfg_max;
                end
                else
                begin
                    mj_reg <= ROW_W'(cfg_max);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg  <= cur_row_next;
        move_reg     <= move_next;
        pass_reg     <= pass_next;
        rad_reg      <= rad_next;
        rad2_reg     <= rad2_next;
        s_hi_reg     <= s_hi_next;
        tcol_reg     <= tcol_next;
        trow_reg     <= trow_next;
        walk_reg     <= walk_next;
        cpy_addr_reg <= cnt_reg;
        q_col_reg    <= col;
        q_row_reg    <= row;
        if (finish)
        begin
            in_window_reg    <= res_in;
            column_empty_reg <= res_empty;
            col_min_reg      <= res_min;
            col_max_reg      <= res_max;
            cell_count_reg   <= total_next;
        end
    end

    assign busy         = (state_reg != dsw_pkg::S_IDLE);
    assign done         = done_reg;
    assign in_window    = in_window_reg;
    assign column_empty = column_empty_reg;
    assign col_min      = col_min_reg;
    assign col_max      = col_max_reg;
    assign cell_count   = cell_count_reg;

    a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsw_pkg::S_CLEAR |-> total_reg == '0)
        else $error("window count not zero during clearing pass");

    a_rmw_origin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsw_pkg::S_RMW |->
            ($past(state_reg) == dsw_pkg::S_IDLE || $past(state_reg) == dsw_pkg::S_MOVE))
        else $error("read-modify-write without a preceding read");

    a_snap_copy: assert property (@(posedge clk) disable iff (!rst_n)
        cpy_vld_reg |-> $past(state_reg) == dsw_pkg::S_COPY)
        else $error("snapshot written outside the copy phase");

    a_walk_snap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsw_pkg::S_SRD |-> !cpy_vld_reg)
        else $error("snapshot read overlaps a pending copy write");

endmodule
`default_nettype wire
